// ===== rtl/fmrt_pkg.sv =====
// ---------------------------------------------------------------------------
// fmrt_pkg
// Shared types, constants and the control store of the flow meter totalizer.
// ---------------------------------------------------------------------------
package fmrt_pkg;

  // Field and register widths
  localparam int TIME_W     = 32;
  localparam int Q_W        = 10;
  localparam int SAMP_W     = 12;
  localparam int RATE_W     = 20;
  localparam int VOL_W      = 24;
  localparam int TOT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Defaults for the top-level parameters
  localparam int METER_COUNT_DEF = 2;
  localparam int PULSE_BITS_DEF  = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_QFACTOR_FIRST    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QFACTOR_SECOND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLING_SECONDS = 2'd2;

  localparam logic [Q_W-1:0]    QFACTOR_RESET  = 10'd45;
  localparam logic [SAMP_W-1:0] SAMPLING_RESET = 12'd1;

  // Arithmetic constants
  localparam int                SCALE_W     = 20;
  localparam logic [SCALE_W-1:0] RATE_SCALE = 20'd1000000;
  localparam logic [RATE_W-1:0] RATE_MAX    = {RATE_W{1'b1}};
  localparam logic [VOL_W-1:0]  VOL_MAX     = {VOL_W{1'b1}};
  // floor(x/3) = (x * RECIP3) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0]       RECIP3      = 32'hAAAA_AAAB;
  localparam int                RECIP_SHIFT = 33;

  // Micro-operations driven into the datapath
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_PULSE,
    OP_MUL,
    OP_SAT,
    OP_DIV,
    OP_VMUL,
    OP_VDIV,
    OP_TOTAL,
    OP_OUT
  } op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOGO,
    C_NOTREAD,
    C_SKIPDIV,
    C_DIVMORE,
    C_OUTBUSY
  } cond_e;

  localparam int PC_W = 4;

  // Program steps
  localparam logic [PC_W-1:0] S_IDLE = 4'd0;
  localparam logic [PC_W-1:0] S_DISP = 4'd1;
  localparam logic [PC_W-1:0] S_MUL  = 4'd2;
  localparam logic [PC_W-1:0] S_SAT  = 4'd3;
  localparam logic [PC_W-1:0] S_DIV  = 4'd4;
  localparam logic [PC_W-1:0] S_VMUL = 4'd5;
  localparam logic [PC_W-1:0] S_VDIV = 4'd6;
  localparam logic [PC_W-1:0] S_TOT  = 4'd7;
  localparam logic [PC_W-1:0] S_OUT  = 4'd8;
  localparam logic [PC_W-1:0] S_RET  = 4'd9;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic go;        // input word taken this cycle
    logic is_read;   // latched word is a read of a valid meter
    logic skip_div;  // zero interval or saturated rate
    logic div_more;  // divider has steps left
    logic out_busy;  // output slot still occupied
  } stat_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    begin
      unique case (pc)
        S_IDLE:  w = '{op: OP_LATCH, cond: C_NOGO,    target: S_IDLE};
        S_DISP:  w = '{op: OP_PULSE, cond: C_NOTREAD, target: S_IDLE};
        S_MUL:   w = '{op: OP_MUL,   cond: C_NEXT,    target: S_IDLE};
        S_SAT:   w = '{op: OP_SAT,   cond: C_SKIPDIV, target: S_VMUL};
        S_DIV:   w = '{op: OP_DIV,   cond: C_DIVMORE, target: S_DIV};
        S_VMUL:  w = '{op: OP_VMUL,  cond: C_NEXT,    target: S_IDLE};
        S_VDIV:  w = '{op: OP_VDIV,  cond: C_NEXT,    target: S_IDLE};
        S_TOT:   w = '{op: OP_TOTAL, cond: C_NEXT,    target: S_IDLE};
        S_OUT:   w = '{op: OP_OUT,   cond: C_OUTBUSY, target: S_OUT};
        S_RET:   w = '{op: OP_NOP,   cond: C_ALWAYS,  target: S_IDLE};
        default: w = '{op: OP_NOP,   cond: C_ALWAYS,  target: S_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage

// ===== rtl/flow_meter_rate_totalizer.sv =====
// ---------------------------------------------------------------------------
// flow_meter_rate_totalizer
// Two-channel pulse flow meter with flow rate and volume totalizer.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per event:
//   mode_i = 0 counts a sensor pulse on meter_select_i, mode_i = 1 reads it.
//   A pulse word gives no result; it passes the accept and dispatch steps.
//   A read word passes accept, dispatch, multiply, range check, the divider
//   steps (one quotient bit a cycle in the shared restoring divider), volume
//   multiply, volume divide and total, loading of the output register and
//   return. Zero interval or a saturated rate skips the divider. The divider
//   sets the read rate.
//   Output channel (out_valid_o / out_stall_i) holds one result word in a
//   register; the sequencer may finish the next pulse words meanwhile and
//   waits at the output step if a new read result finds the slot full.
//   Configuration (cfg_we_i / cfg_index_i / cfg_wdata_i) writes qfactor
//   for meter 0 and meter 1 and the sampling seconds; write only when idle.
//   Reset clears counters, read timestamps and totals; qfactors come up at
//   45 and sampling seconds at 1. No clearing pass is needed.
// ---------------------------------------------------------------------------
module flow_meter_rate_totalizer #(
  parameter int METER_COUNT = fmrt_pkg::METER_COUNT_DEF,
  parameter int PULSE_BITS  = fmrt_pkg::PULSE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic                                meter_select_i,
  input  logic [fmrt_pkg::TIME_W-1:0]         now_ms_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fmrt_pkg::RATE_W-1:0]         flow_centi_lpm_o,
  output logic [fmrt_pkg::VOL_W-1:0]          interval_ml_o,
  output logic [fmrt_pkg::TOT_W-1:0]          total_ml_o,
  output logic                                zero_interval_o,
  output logic                                meter_id_o,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [fmrt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fmrt_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  logic [fmrt_pkg::Q_W-1:0]    qf0_q, qf1_q;
  logic [fmrt_pkg::SAMP_W-1:0] samp_q;

  fmrt_pkg::ctrl_t ctrl;
  fmrt_pkg::stat_t stat;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qf0_q  <= fmrt_pkg::QFACTOR_RESET;
      qf1_q  <= fmrt_pkg::QFACTOR_RESET;
      samp_q <= fmrt_pkg::SAMPLING_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fmrt_pkg::REG_QFACTOR_FIRST:    qf0_q  <= cfg_wdata_i[fmrt_pkg::Q_W-1:0];
        fmrt_pkg::REG_QFACTOR_SECOND:   qf1_q  <= cfg_wdata_i[fmrt_pkg::Q_W-1:0];
        fmrt_pkg::REG_SAMPLING_SECONDS: samp_q <= cfg_wdata_i[fmrt_pkg::SAMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Microcode sequencer: one control word per step
  fmrt_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Datapath: meter state, arithmetic, output register
  fmrt_dp #(
    .METER_COUNT (METER_COUNT),
    .PULSE_BITS  (PULSE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .qf0_i            (qf0_q),
    .qf1_i            (qf1_q),
    .samp_i           (samp_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .meter_select_i   (meter_select_i),
    .now_ms_i         (now_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .flow_centi_lpm_o (flow_centi_lpm_o),
    .interval_ml_o    (interval_ml_o),
    .total_ml_o       (total_ml_o),
    .zero_interval_o  (zero_interval_o),
    .meter_id_o       (meter_id_o)
  );

endmodule

// ===== rtl/fmrt_seq.sv =====
// ---------------------------------------------------------------------------
// fmrt_seq
// Step counter and control store; picks the next step from the jump field.
// ---------------------------------------------------------------------------
module fmrt_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fmrt_pkg::stat_t     stat_i,
  output fmrt_pkg::ctrl_t     ctrl_o
);

  logic [fmrt_pkg::PC_W-1:0] pc_q, pc_d;
  fmrt_pkg::ctrl_t           ctrl;
  logic                      jump;

  assign ctrl   = fmrt_pkg::ucode(pc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    unique case (ctrl.cond)
      fmrt_pkg::C_NEXT:    jump = 1'b0;
      fmrt_pkg::C_ALWAYS:  jump = 1'b1;
      fmrt_pkg::C_NOGO:    jump = !stat_i.go;
      fmrt_pkg::C_NOTREAD: jump = !stat_i.is_read;
      fmrt_pkg::C_SKIPDIV: jump = stat_i.skip_div;
      fmrt_pkg::C_DIVMORE: jump = stat_i.div_more;
      fmrt_pkg::C_OUTBUSY: jump = stat_i.out_busy;
      default:             jump = 1'b1;
    endcase
    pc_d = jump ? ctrl.target : pc_q + fmrt_pkg::PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= fmrt_pkg::S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/fmrt_dp.sv =====
// ---------------------------------------------------------------------------
// fmrt_dp
// Meter state, multipliers, restoring divider and output register.
// ---------------------------------------------------------------------------
module fmrt_dp #(
  parameter int METER_COUNT = fmrt_pkg::METER_COUNT_DEF,
  parameter int PULSE_BITS  = fmrt_pkg::PULSE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fmrt_pkg::ctrl_t                 ctrl_i,
  output fmrt_pkg::stat_t                 stat_o,
  input  logic [fmrt_pkg::Q_W-1:0]        qf0_i,
  input  logic [fmrt_pkg::Q_W-1:0]        qf1_i,
  input  logic [fmrt_pkg::SAMP_W-1:0]     samp_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic                            meter_select_i,
  input  logic [fmrt_pkg::TIME_W-1:0]     now_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fmrt_pkg::RATE_W-1:0]     flow_centi_lpm_o,
  output logic [fmrt_pkg::VOL_W-1:0]      interval_ml_o,
  output logic [fmrt_pkg::TOT_W-1:0]      total_ml_o,
  output logic                            zero_interval_o,
  output logic                            meter_id_o
);

  localparam int IDX_W    = (METER_COUNT > 1) ? $clog2(METER_COUNT) : 1;
  localparam int NUM_W    = PULSE_BITS + fmrt_pkg::SCALE_W;
  localparam int DEN_W    = fmrt_pkg::TIME_W + fmrt_pkg::Q_W;
  localparam int CMP_W    = DEN_W + fmrt_pkg::RATE_W;
  localparam int DSH_W    = CMP_W - 1;
  localparam int CNT_W    = $clog2(fmrt_pkg::RATE_W);
  localparam int PROD_W   = fmrt_pkg::SAMP_W + fmrt_pkg::RATE_W;
  localparam int RPROD_W  = PROD_W - 1 + 32;
  localparam int VRAW_W   = RPROD_W - fmrt_pkg::RECIP_SHIFT;
  localparam logic [PULSE_BITS-1:0] PULSE_MAX = {PULSE_BITS{1'b1}};

  // per-meter state
  logic [PULSE_BITS-1:0]          pulse_q [METER_COUNT];
  logic [fmrt_pkg::TIME_W-1:0]    prev_q  [METER_COUNT];
  logic [fmrt_pkg::TOT_W-1:0]     total_q [METER_COUNT];

  // latched word and working registers
  logic                           mode_q, meter_q;
  logic [fmrt_pkg::TIME_W-1:0]    now_q;
  logic [NUM_W-1:0]               num_q, rem_q;
  logic [DEN_W-1:0]               den_q;
  logic [DSH_W-1:0]               dsh_q;
  logic [CNT_W-1:0]               cnt_q;
  logic [fmrt_pkg::RATE_W-1:0]    quo_q;
  logic                           zero_q;
  logic [PROD_W-1:0]              vprod_q;
  logic [RPROD_W-1:0]             rprod_q;
  logic                           out_valid_q;

  logic                           go, sel_ok, out_busy, sat;
  logic [IDX_W-1:0]               idx;
  logic [fmrt_pkg::Q_W-1:0]       q_raw, q_eff;
  logic [fmrt_pkg::TIME_W-1:0]    elapsed;
  logic [VRAW_W-1:0]              vraw;
  logic [fmrt_pkg::VOL_W-1:0]     vol;
  logic                           take;

  assign in_stall_o = (ctrl_i.op != fmrt_pkg::OP_LATCH);
  assign go         = in_valid_i && !in_stall_o;
  assign sel_ok     = (32'(meter_q) < METER_COUNT);
  assign idx        = IDX_W'(meter_q);
  assign out_busy   = out_valid_q && out_stall_i;

  assign q_raw   = meter_q ? qf1_i : qf0_i;
  assign q_eff   = (q_raw == '0) ? fmrt_pkg::Q_W'(1) : q_raw;
  assign elapsed = now_q - prev_q[idx];

  // rate of 2^20 or more saturates; checked before the divider runs
  assign sat = CMP_W'(num_q) >= (CMP_W'(den_q) << fmrt_pkg::RATE_W);
  assign take = DSH_W'(rem_q) >= dsh_q;

  assign vraw = rprod_q[RPROD_W-1:fmrt_pkg::RECIP_SHIFT];
  assign vol  = (|vraw[VRAW_W-1:fmrt_pkg::VOL_W]) ? fmrt_pkg::VOL_MAX
                                                  : vraw[fmrt_pkg::VOL_W-1:0];

  assign stat_o.go       = go;
  assign stat_o.is_read  = sel_ok && mode_q;
  assign stat_o.skip_div = zero_q || sat;
  assign stat_o.div_more = (cnt_q != '0);
  assign stat_o.out_busy = out_busy;

  // meter state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < METER_COUNT; i++) begin
        pulse_q[i] <= '0;
        prev_q[i]  <= '0;
        total_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.op == fmrt_pkg::OP_PULSE && sel_ok && !mode_q &&
          pulse_q[idx] != PULSE_MAX) begin
        pulse_q[idx] <= pulse_q[idx] + PULSE_BITS'(1);
      end
      if (ctrl_i.op == fmrt_pkg::OP_TOTAL) begin
        pulse_q[idx] <= '0;
        prev_q[idx]  <= now_q;
        // zero rate clears the total
        total_q[idx] <= (quo_q == '0) ? '0 : total_q[idx] + fmrt_pkg::TOT_W'(vol);
      end
      if (ctrl_i.op == fmrt_pkg::OP_OUT && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      fmrt_pkg::OP_LATCH: begin
        if (go) begin
          mode_q  <= mode_i;
          meter_q <= meter_select_i;
          now_q   <= now_ms_i;
        end
      end
      fmrt_pkg::OP_MUL: begin
        num_q  <= NUM_W'(pulse_q[idx]) * NUM_W'(fmrt_pkg::RATE_SCALE);
        den_q  <= DEN_W'(elapsed) * DEN_W'(q_eff);
        zero_q <= (elapsed == '0);
      end
      fmrt_pkg::OP_SAT: begin
        rem_q <= num_q;
        dsh_q <= DSH_W'(den_q) << (fmrt_pkg::RATE_W - 1);
        cnt_q <= CNT_W'(fmrt_pkg::RATE_W - 1);
        quo_q <= (!zero_q && sat) ? fmrt_pkg::RATE_MAX : '0;
      end
      fmrt_pkg::OP_DIV: begin
        if (take) begin
          rem_q <= rem_q - NUM_W'(dsh_q);
        end
        quo_q <= {quo_q[fmrt_pkg::RATE_W-2:0], take};
        dsh_q <= dsh_q >> 1;
        cnt_q <= cnt_q - CNT_W'(1);
      end
      fmrt_pkg::OP_VMUL: begin
        vprod_q <= PROD_W'(samp_i) * PROD_W'(quo_q);
      end
      fmrt_pkg::OP_VDIV: begin
        // volume / 6 as (volume / 2) / 3
        rprod_q <= RPROD_W'(vprod_q[PROD_W-1:1]) * RPROD_W'(fmrt_pkg::RECIP3);
      end
      fmrt_pkg::OP_OUT: begin
        if (!out_busy) begin
          flow_centi_lpm_o <= quo_q;
          interval_ml_o    <= (quo_q == '0) ? '0 : vol;
          total_ml_o       <= total_q[idx];
          zero_interval_o  <= zero_q;
          meter_id_o       <= meter_q;
        end
      end
      fmrt_pkg::OP_NOP, fmrt_pkg::OP_PULSE, fmrt_pkg::OP_TOTAL: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
